@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/dsip_pkg.sv @@
// ----------------------------------------------------------------------------
// dsip_pkg
// Types and constants shared by the decimal text parser modules.
// ----------------------------------------------------------------------------
package dsip_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_LOW_E = 8'h65;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH_SEL = 2'd0;
  localparam logic [1:0] CFG_STRICT    = 2'd1;

  // Queue between the classifier and the parser.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Quotient bits produced per cycle by the divide-by-ten unit.
  localparam int DIV_BITS = 8;

  typedef enum logic [2:0] {
    CL_NONE,
    CL_DIGIT,
    CL_BLANK,
    CL_POINT,
    CL_EXP,
    CL_MINUS,
    CL_NUL,
    CL_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        last;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t ent;
  } q_push_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } q_head_t;

  typedef struct packed {
    logic [1:0] width_sel;
    logic       strict_mode;
  } cfg_t;

endpackage

@@ hdl/dsip_front.sv @@
// ----------------------------------------------------------------------------
// dsip_front
// Accepts input words and classifies each character for the parser queue.
// ----------------------------------------------------------------------------
module dsip_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] ch
  input  logic              in_tuser,   // [0] has_char
  input  logic              in_tlast,
  input  logic              q_full,
  output dsip_pkg::q_push_t push
);
  import dsip_pkg::*;

  char_class_t cls;

  always_comb begin
    if (!in_tuser) begin
      cls = CL_NONE;
    end else if (in_tdata == CH_NUL) begin
      cls = CL_NUL;
    end else if (in_tdata >= CH_ZERO && in_tdata <= CH_NINE) begin
      cls = CL_DIGIT;
    end else if (in_tdata == CH_SPACE || (in_tdata >= CH_TAB && in_tdata <= CH_CR)) begin
      cls = CL_BLANK;
    end else if (in_tdata == CH_POINT) begin
      cls = CL_POINT;
    end else if (in_tdata == CH_LOW_E || in_tdata == CH_UP_E) begin
      cls = CL_EXP;
    end else if (in_tdata == CH_MINUS) begin
      cls = CL_MINUS;
    end else begin
      cls = CL_OTHER;
    end
  end

  assign in_tready = !q_full;

  // A word without a character that does not end the text changes nothing,
  // so it is dropped here rather than queued.
  assign push.push      = in_tvalid && !q_full && (in_tuser || in_tlast);
  assign push.ent.cls   = cls;
  assign push.ent.digit = (cls == CL_DIGIT) ? in_tdata[3:0] : 4'd0;
  assign push.ent.last  = in_tlast;

endmodule

@@ hdl/dsip_queue.sv @@
// ----------------------------------------------------------------------------
// dsip_queue
// Short first-in first-out queue of classified characters.
// ----------------------------------------------------------------------------
module dsip_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  dsip_pkg::q_push_t push,
  output logic              full,
  output dsip_pkg::q_head_t head,
  input  logic              pop
);
  import dsip_pkg::*;

  qent_t          slots_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full       = (cnt_r == (QAW+1)'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.ent   = slots_r[rp_r];

  assign do_push = push.push && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wp_nxt  = do_push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = do_pop  ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wp_r] <= push.ent;
    end
  end

endmodule

@@ hdl/dsip_back.sv @@
// ----------------------------------------------------------------------------
// dsip_back
// Parse sequencer: accumulates digits, applies the exponent, holds the result.
// ----------------------------------------------------------------------------
module dsip_back #(
  parameter int MAX_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dsip_pkg::cfg_t    cfg,
  input  dsip_pkg::q_head_t head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,
  output logic              out_tuser
);
  import dsip_pkg::*;

  localparam int AW   = MAX_WIDTH;
  localparam int XW   = AW + 4;
  localparam int NDIV = (AW + DIV_BITS - 1) / DIV_BITS;
  localparam int DW   = NDIV * DIV_BITS;
  localparam int DCW  = (NDIV > 1) ? $clog2(NDIV) : 1;

  typedef enum logic [9:0] {
    PH_LEAD     = 10'b00_0000_0001,
    PH_MANT     = 10'b00_0000_0010,
    PH_FRAC     = 10'b00_0000_0100,
    PH_TRAIL    = 10'b00_0000_1000,
    PH_EXPSTART = 10'b00_0001_0000,
    PH_EXP      = 10'b00_0010_0000,
    PH_EXPFRAC  = 10'b00_0100_0000,
    PH_EXPTRAIL = 10'b00_1000_0000,
    PH_FAIL     = 10'b01_0000_0000,
    PH_DONE     = 10'b10_0000_0000
  } phase_t;

  typedef enum logic [4:0] {
    SQ_TAKE  = 5'b00001,
    SQ_FIN   = 5'b00010,
    SQ_SCALE = 5'b00100,
    SQ_DIV   = 5'b01000,
    SQ_RES   = 5'b10000
  } seq_t;

  seq_t                 seq_r, seq_nxt;
  phase_t               phase_r, phase_nxt;
  logic signed [AW-1:0] accum_r, accum_nxt;
  logic                 neg_r, neg_nxt;
  logic                 saw_r, saw_nxt;
  logic [5:0]           exp_r, exp_nxt;
  logic                 exp_neg_r, exp_neg_nxt;
  logic                 exp_dig_r, exp_dig_nxt;
  logic [5:0]           k_r, k_nxt;
  logic                 emit_r, emit_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic [DW-1:0]        dq_r, dq_nxt;
  logic [3:0]           drem_r, drem_nxt;
  logic [DCW-1:0]       dc_r, dc_nxt;
  logic                 dneg_r, dneg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [63:0]          out_value_r, out_value_nxt;
  logic                 out_ok_r, out_ok_nxt;

  int                   eff_w;
  logic signed [XW-1:0] hi_x, lo_x;
  logic signed [XW-1:0] acc_x, mul10_x, dig_x, sum_x;
  logic                 dig_ovf, mul_ovf;
  logic [9:0]           e_sum;
  logic [AW-1:0]        mag;
  logic [DW-1:0]        q_w;
  logic [3:0]           r_w;
  logic [4:0]           t_w;
  logic [AW-1:0]        quo;
  logic                 active, handled, out_free;
  char_class_t          cls;

  // Range limits of the selected target width.
  always_comb begin
    eff_w = 8 << cfg.width_sel;
    if (eff_w > AW) begin
      eff_w = AW;
    end
    hi_x = (XW'(1) <<< (eff_w - 1)) - XW'(1);
    lo_x = -hi_x - XW'(1);
  end

  // Times ten, plus or minus a digit, with the bound check on the wide sum.
  assign acc_x   = XW'(accum_r);
  assign mul10_x = (acc_x <<< 3) + (acc_x <<< 1);
  assign dig_x   = XW'(head.ent.digit);
  assign sum_x   = neg_r ? mul10_x - dig_x : mul10_x + dig_x;
  assign dig_ovf = neg_r ? (sum_x < lo_x) : (sum_x > hi_x);
  assign mul_ovf = (mul10_x > hi_x) || (mul10_x < lo_x);

  assign e_sum = (10'(exp_r) << 3) + (10'(exp_r) << 1) + 10'(head.ent.digit);
  assign mag   = accum_r[AW-1] ? AW'(-accum_r) : AW'(accum_r);

  // Restoring division by ten, several quotient bits per cycle.
  always_comb begin
    q_w = dq_r;
    r_w = drem_r;
    t_w = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t_w = {r_w, q_w[DW-1]};
      q_w = {q_w[DW-2:0], 1'b0};
      if (t_w >= 5'd10) begin
        r_w    = 4'(t_w - 5'd10);
        q_w[0] = 1'b1;
      end else begin
        r_w = t_w[3:0];
      end
    end
  end

  assign quo      = q_w[AW-1:0];
  assign cls      = head.ent.cls;
  assign out_free = !out_valid_r || out_tready;
  assign active   = (phase_r != PH_FAIL) && (phase_r != PH_DONE);
  assign pop      = (seq_r == SQ_TAKE) && head.valid;

  always_comb begin
    seq_nxt       = seq_r;
    phase_nxt     = phase_r;
    accum_nxt     = accum_r;
    neg_nxt       = neg_r;
    saw_nxt       = saw_r;
    exp_nxt       = exp_r;
    exp_neg_nxt   = exp_neg_r;
    exp_dig_nxt   = exp_dig_r;
    k_nxt         = k_r;
    emit_nxt      = emit_r;
    res_ok_nxt    = res_ok_r;
    dq_nxt        = dq_r;
    drem_nxt      = drem_r;
    dc_nxt        = dc_r;
    dneg_nxt      = dneg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_ok_nxt    = out_ok_r;
    handled       = 1'b0;

    case (seq_r)
      SQ_TAKE: begin
        if (head.valid) begin
          emit_nxt = head.ent.last;
          if (active && cls != CL_NONE && cls != CL_NUL) begin
            if (phase_nxt == PH_LEAD) begin
              if (cls == CL_BLANK) begin
                handled = 1'b1;
              end else begin
                phase_nxt = PH_MANT;
                if (cls == CL_MINUS) begin
                  neg_nxt = 1'b1;
                  handled = 1'b1;
                end
              end
            end
            if (!handled && phase_nxt == PH_EXPSTART) begin
              phase_nxt = PH_EXP;
              if (cls == CL_MINUS) begin
                exp_neg_nxt = 1'b1;
                handled     = 1'b1;
              end
            end
            if (!handled) begin
              case (phase_nxt)
                PH_MANT: begin
                  if (cls == CL_DIGIT) begin
                    if (dig_ovf) begin
                      phase_nxt = PH_FAIL;
                    end else begin
                      accum_nxt = sum_x[AW-1:0];
                      saw_nxt   = 1'b1;
                    end
                  end else if (cls == CL_POINT) begin
                    phase_nxt = cfg.strict_mode ? PH_FAIL : PH_FRAC;
                  end else if (cls == CL_BLANK) begin
                    phase_nxt = PH_TRAIL;
                  end else if (cls == CL_EXP) begin
                    phase_nxt = PH_EXPSTART;
                  end else begin
                    phase_nxt = PH_FAIL;
                  end
                end
                PH_EXP: begin
                  if (cls == CL_DIGIT) begin
                    exp_nxt     = (e_sum > 10'd63) ? 6'd63 : e_sum[5:0];
                    exp_dig_nxt = 1'b1;
                  end else if (cls == CL_POINT) begin
                    phase_nxt = cfg.strict_mode ? PH_FAIL : PH_EXPFRAC;
                  end else if (cls == CL_BLANK) begin
                    phase_nxt = PH_EXPTRAIL;
                  end else begin
                    phase_nxt = PH_FAIL;
                  end
                end
                PH_FRAC, PH_EXPFRAC: begin
                  if (cls != CL_DIGIT) begin
                    phase_nxt = PH_FAIL;
                  end
                end
                PH_TRAIL, PH_EXPTRAIL: begin
                  if (cls != CL_BLANK) begin
                    phase_nxt = PH_FAIL;
                  end
                end
                default: begin
                end
              endcase
            end
          end
          // A zero byte ends the text early; the last word always settles it.
          if (head.ent.last || (active && cls == CL_NUL)) begin
            seq_nxt = SQ_FIN;
          end
        end
      end

      SQ_FIN: begin
        case (phase_r)
          PH_MANT: begin
            res_ok_nxt = saw_r;
            if (!saw_r) begin
              accum_nxt = '0;
            end
            seq_nxt = SQ_RES;
          end
          PH_FRAC, PH_TRAIL, PH_DONE: begin
            res_ok_nxt = 1'b1;
            seq_nxt    = SQ_RES;
          end
          PH_EXP: begin
            if (exp_dig_r) begin
              k_nxt   = '0;
              seq_nxt = SQ_SCALE;
            end else begin
              res_ok_nxt = 1'b0;
              accum_nxt  = '0;
              seq_nxt    = SQ_RES;
            end
          end
          PH_EXPFRAC, PH_EXPTRAIL: begin
            k_nxt   = '0;
            seq_nxt = SQ_SCALE;
          end
          default: begin
            res_ok_nxt = 1'b0;
            accum_nxt  = '0;
            seq_nxt    = SQ_RES;
          end
        endcase
      end

      SQ_SCALE: begin
        if (k_r >= exp_r || accum_r == '0) begin
          res_ok_nxt = 1'b1;
          seq_nxt    = SQ_RES;
        end else if (exp_neg_r) begin
          dq_nxt   = DW'(mag);
          drem_nxt = '0;
          dc_nxt   = '0;
          dneg_nxt = accum_r[AW-1];
          seq_nxt  = SQ_DIV;
        end else if (mul_ovf) begin
          res_ok_nxt = 1'b0;
          accum_nxt  = '0;
          seq_nxt    = SQ_RES;
        end else begin
          accum_nxt = mul10_x[AW-1:0];
          k_nxt     = k_r + 6'd1;
        end
      end

      SQ_DIV: begin
        dq_nxt   = q_w;
        drem_nxt = r_w;
        dc_nxt   = dc_r + DCW'(1);
        if (dc_r == DCW'(NDIV - 1)) begin
          accum_nxt = dneg_r ? signed'(AW'(-quo)) : signed'(quo);
          k_nxt     = k_r + 6'd1;
          seq_nxt   = SQ_SCALE;
        end
      end

      SQ_RES: begin
        if (emit_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = 64'(accum_r);
            out_ok_nxt    = res_ok_r;
            phase_nxt     = PH_LEAD;
            accum_nxt     = '0;
            neg_nxt       = 1'b0;
            saw_nxt       = 1'b0;
            exp_nxt       = '0;
            exp_neg_nxt   = 1'b0;
            exp_dig_nxt   = 1'b0;
            seq_nxt       = SQ_TAKE;
          end
        end else begin
          phase_nxt = res_ok_r ? PH_DONE : PH_FAIL;
          seq_nxt   = SQ_TAKE;
        end
      end

      default: begin
        seq_nxt = SQ_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SQ_TAKE;
      phase_r     <= PH_LEAD;
      accum_r     <= '0;
      neg_r       <= 1'b0;
      saw_r       <= 1'b0;
      exp_r       <= '0;
      exp_neg_r   <= 1'b0;
      exp_dig_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      phase_r     <= phase_nxt;
      accum_r     <= accum_nxt;
      neg_r       <= neg_nxt;
      saw_r       <= saw_nxt;
      exp_r       <= exp_nxt;
      exp_neg_r   <= exp_neg_nxt;
      exp_dig_r   <= exp_dig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    emit_r      <= emit_nxt;
    res_ok_r    <= res_ok_nxt;
    dq_r        <= dq_nxt;
    drem_r      <= drem_nxt;
    dc_r        <= dc_nxt;
    dneg_r      <= dneg_nxt;
    out_value_r <= out_value_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_ok_r;

endmodule

@@ hdl/decimal_string_to_int_parser.sv @@
// ----------------------------------------------------------------------------
// decimal_string_to_int_parser
// Streaming decimal text to signed integer converter with range check.
// ----------------------------------------------------------------------------
// Usage: text arrives one character per word on the in_ channel; in_tuser
// says whether the word carries a character and in_tlast marks the final
// word of the text. For each text one word leaves on the out_ channel with
// the signed value in out_tdata and the ok flag in out_tuser.
// Throughput: one character word per cycle, set by the single digit step of
// the parse sequencer, while it is taking words rather than closing a text.
// After the final word the sequencer passes through a verdict state and a
// result hand-over state. An exponent adds a closing scale check and a
// multiply by ten per positive exponent step; a negative exponent step runs
// the divide-by-ten unit, which produces eight quotient bits a cycle. Scaling
// stops early once the value reaches zero and the result is handed over.
// A four-entry queue separates the classifier from the sequencer, so input
// keeps flowing while the exponent is applied or the receiver stalls; the
// result waits in its output register and in_tready falls once the queue
// fills. Reset sets width_sel to 64 bits and strict_mode off, empties the
// queue and returns the parser to the leading space phase; no clearing pass.
// Configuration words (cfg_index, cfg_data) are always accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_string_to_int_parser #(
  parameter int MAX_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] ch
  input  logic        in_tuser,    // [0] has_char
  input  logic        in_tlast,    // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [63:0] value
  output logic        out_tuser,   // [0] ok
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);
  import dsip_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  q_push_t push;
  q_head_t head;
  logic    q_full;
  logic    pop;
  logic    fits_8, fits_16;

  // Configuration registers. Writes to an index outside the map are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH_SEL: cfg_nxt.width_sel   = cfg_data;
        CFG_STRICT:    cfg_nxt.strict_mode = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_sel   <= 2'd3;
      cfg_r.strict_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end classifies each character and drops words that carry
  // nothing, so the sequencer only sees work that matters.
  dsip_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push)
  );

  dsip_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  // The back end runs the parse phases and the exponent scaling, and owns
  // the output register.
  dsip_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // The output word read as a sign-extended 8-bit or 16-bit value.
  assign fits_8  = (out_tdata[63:7] == {57{out_tdata[7]}});
  assign fits_16 = (out_tdata[63:15] == {49{out_tdata[15]}});

  // A rejected text always reports zero.
  `ASSERT_IMPLY(a_fail_is_zero, out_tvalid, out_tuser || out_tdata == 64'd0, "fail not zero")
  // A result fits the selected 8-bit or 16-bit width as a sign-extended value.
  `ASSERT_IMPLY(a_range_8, out_tvalid && cfg_r.width_sel == 2'd0, fits_8, "over 8-bit range")
  `ASSERT_IMPLY(a_range_16, out_tvalid && cfg_r.width_sel == 2'd1, fits_16, "over 16-bit range")

endmodule

@@ tb/tb_decimal_string_to_int_parser.sv @@
// ----------------------------------------------------------------------------
// tb_decimal_string_to_int_parser
// Self-checking bench for the streaming decimal text to integer converter.
// Texts go in one character word at a time and are scored against a local
// parse of the same words. Directed texts, the width and strict-mode limits,
// random texts, a stretch with no idling and a long receiver hold-off are
// run, with random idling on both streams elsewhere.
// ----------------------------------------------------------------------------
module tb_decimal_string_to_int_parser;
  import dsip_pkg::*;

  localparam int MAX_W        = 64;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // The queue holds four words, and a negative exponent step runs the divide
  // unit, so this covers any word still in flight once the results are in.
  localparam int DRAIN_CYCLES = 24;
  localparam int ITEM_TARGET  = 1450;
  localparam int HOLD_CYCLES  = 400;

  // Parse phases of the local predictor.
  typedef enum logic [3:0] {
    P_LEAD, P_MANT, P_FRAC, P_TRAIL, P_EXPSTART,
    P_EXP, P_EXPFRAC, P_EXPTRAIL, P_FAIL, P_DONE
  } parse_phase_t;

  typedef struct {
    logic signed [63:0] value;
    logic               ok;
  } result_t;

  typedef logic [7:0] text_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] ch
  logic        in_tuser = 1'b0;  // [0] has_char
  logic        in_tlast = 1'b0;  // last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;        // [63:0] value
  logic        out_tuser;        // [0] ok
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [1:0]  cfg_data = '0;

  decimal_string_to_int_parser #(.MAX_WIDTH(MAX_W)) uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected results, oldest first, and the bench-wide bookkeeping.
  result_t results_due[$];
  int      errors = 0;
  int      words_sent = 0;
  int      cycle_count = 0;
  bit      tx_gaps = 1'b1;
  bit      rx_gaps = 1'b1;
  int      hold_asks = 0;
  int      hold_done = 0;

  // Predictor copy of the registers and of the parse state.
  logic [1:0]   cur_wsel = 2'd3;
  logic         cur_strict = 1'b0;
  parse_phase_t ph = P_LEAD;
  longint       acc = 0;
  bit           neg = 1'b0;
  bit           saw_digit = 1'b0;
  int           exp_mag = 0;
  bit           exp_neg = 1'b0;
  logic [1:0]   exp_flags = '0;

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Largest positive value at the selected width.
  function automatic longint top_of_range();
    int w;
    w = 8 << cur_wsel;
    if (w > MAX_W) w = MAX_W;
    if (w >= 64) return 64'sh7FFF_FFFF_FFFF_FFFF;
    return (longint'(1) << (w - 1)) - 1;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Scales the mantissa by the exponent exactly; a negative exponent
  // truncates toward zero and a zero mantissa stops the scaling at once.
  function automatic bit apply_exponent(output longint res);
    longint v, hi, lo;
    v  = acc;
    hi = top_of_range();
    lo = -hi - 1;
    res = 0;
    for (int k = 0; k < exp_mag && v != 0; k++) begin
      if (exp_neg) begin
        v = v / 10;
      end else begin
        if (v > hi / 10 || v < lo / 10) return 1'b0;
        v = v * 10;
      end
    end
    res = v;
    return 1'b1;
  endfunction

  // Verdict on the text so far, as given when the text ends.
  function automatic bit verdict(output longint res);
    res = 0;
    case (ph)
      P_MANT: begin
        if (!saw_digit) return 1'b0;
        res = acc;
        return 1'b1;
      end
      P_FRAC, P_TRAIL, P_DONE: begin
        res = acc;
        return 1'b1;
      end
      P_EXP: begin
        if (!exp_flags[0]) return 1'b0;
        return apply_exponent(res);
      end
      P_EXPFRAC, P_EXPTRAIL: return apply_exponent(res);
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_text();
    ph        = P_LEAD;
    acc       = 0;
    neg       = 1'b0;
    saw_digit = 1'b0;
    exp_mag   = 0;
    exp_neg   = 1'b0;
    exp_flags = '0;
  endfunction

  function automatic void take_char(logic [7:0] c);
    longint hi, lo, d;
    hi = top_of_range();
    lo = -hi - 1;
    if (ph == P_LEAD) begin
      if (is_blank(c)) return;
      ph = P_MANT;
      if (c == CH_MINUS) begin
        neg = 1'b1;
        return;
      end
    end
    if (ph == P_EXPSTART) begin
      ph = P_EXP;
      if (c == CH_MINUS) begin
        exp_neg = 1'b1;
        return;
      end
    end
    case (ph)
      P_MANT: begin
        if (is_digit(c)) begin
          d = longint'(c - CH_ZERO);
          // The range check is exact: it runs before the multiply.
          if (neg) begin
            if (acc < (lo + d) / 10) begin
              ph = P_FAIL;
              return;
            end
            acc = acc * 10 - d;
          end else begin
            if (acc > (hi - d) / 10) begin
              ph = P_FAIL;
              return;
            end
            acc = acc * 10 + d;
          end
          saw_digit = 1'b1;
        end else if (c == CH_POINT) begin
          ph = cur_strict ? P_FAIL : P_FRAC;
        end else if (is_blank(c)) begin
          ph = P_TRAIL;
        end else if (c == CH_LOW_E || c == CH_UP_E) begin
          ph = P_EXPSTART;
          exp_flags[1] = 1'b1;
        end else begin
          ph = P_FAIL;
        end
      end
      P_EXP: begin
        if (is_digit(c)) begin
          // The exponent magnitude saturates at 63.
          exp_mag = exp_mag * 10 + int'(c - CH_ZERO);
          if (exp_mag > 63) exp_mag = 63;
          exp_flags[0] = 1'b1;
        end else if (c == CH_POINT) begin
          ph = cur_strict ? P_FAIL : P_EXPFRAC;
        end else if (is_blank(c)) begin
          ph = P_EXPTRAIL;
        end else begin
          ph = P_FAIL;
        end
      end
      P_FRAC, P_EXPFRAC: begin
        if (!is_digit(c)) ph = P_FAIL;
      end
      P_TRAIL, P_EXPTRAIL: begin
        if (!is_blank(c)) ph = P_FAIL;
      end
      default: ;
    endcase
  endfunction

  // Advances the predictor by one accepted word and queues the result that
  // a final word causes.
  function automatic void parse_word(logic [7:0] c, logic has, logic fin);
    longint  v;
    bit      ok;
    result_t r;
    if (has && ph != P_FAIL && ph != P_DONE) begin
      if (c == CH_NUL) begin
        // A zero byte fixes the verdict; later characters are ignored.
        ok  = verdict(v);
        acc = ok ? v : 0;
        ph  = ok ? P_DONE : P_FAIL;
      end else begin
        take_char(c);
      end
    end
    if (fin) begin
      ok      = verdict(v);
      r.value = ok ? v : 0;
      r.ok    = ok;
      results_due.push_back(r);
      clear_text();
    end
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // Offers one word and waits for it to be taken. With idling on, the
  // stream then drops valid about a third of the time.
  task automatic put_word(logic [7:0] c, logic has, logic fin);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= has;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    parse_word(c, has, fin);
    if (has || fin) words_sent++;
    if (tx_gaps && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Sends one text. Empty words without a character are slipped in now and
  // then, and the end is sometimes marked by such a word of its own.
  task automatic send_text(text_t t);
    bit sep_last;
    sep_last = (t.size() == 0) || ($urandom_range(99) < 12);
    foreach (t[i]) begin
      if ($urandom_range(99) < 4) put_word(8'($urandom_range(255)), 1'b0, 1'b0);
      put_word(t[i], 1'b1, !sep_last && i == t.size() - 1);
    end
    if (sep_last) put_word(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic send_str(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_text(t);
  endtask

  // Waits until every result is in and any trailing word has drained.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH_SEL) cur_wsel = data;
    else if (idx == CFG_STRICT) cur_strict = data[0];
  endtask

  // The upper data bit is random on the strict write; only bit 0 counts.
  task automatic set_config(logic [1:0] wsel, logic strict);
    write_reg(CFG_WIDTH_SEL, wsel);
    write_reg(CFG_STRICT, {1'($urandom_range(1)), strict});
  endtask

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  // Text of the largest or smallest value at the current width; with over
  // set the last digit is raised by one, which always lands just outside.
  function automatic text_t boundary_text(bit lower, bit over);
    text_t  t;
    longint hi;
    string  s;
    hi = top_of_range();
    s  = $sformatf("%0d", lower ? -hi - 1 : hi);
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    if (over) t[t.size() - 1] = t[t.size() - 1] + 8'd1;
    return t;
  endfunction

  // Mostly well-formed numbers with random content, some of them broken by
  // a stray byte or cut short by a zero byte, and a little pure noise.
  function automatic text_t make_text();
    text_t t;
    int    maxdig, n;
    maxdig = (cur_wsel == 2'd0) ? 3 : (cur_wsel == 2'd1) ? 5 :
             (cur_wsel == 2'd2) ? 10 : 19;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(6)) t.push_back(8'($urandom_range(1, 255)));
      return t;
    end
    repeat ($urandom_range(2)) t.push_back(pick_blank());
    if ($urandom_range(99) < 15) begin
      t = {t, boundary_text(1'($urandom_range(1)), 1'($urandom_range(1)))};
    end else begin
      if ($urandom_range(99) < 35) t.push_back(CH_MINUS);
      n = $urandom_range(maxdig + 1);
      repeat (n) t.push_back(pick_digit());
    end
    if ($urandom_range(99) < 20) begin
      t.push_back(CH_POINT);
      repeat ($urandom_range(3)) t.push_back(pick_digit());
    end
    if ($urandom_range(99) < 22) begin
      t.push_back($urandom_range(1) ? CH_UP_E : CH_LOW_E);
      if ($urandom_range(99) < 35) t.push_back(CH_MINUS);
      n = ($urandom_range(99) < 5) ? 0 : ($urandom_range(99) < 85) ? 1 : 2;
      repeat (n) t.push_back(pick_digit());
      if ($urandom_range(99) < 8) begin
        t.push_back(CH_POINT);
        t.push_back(pick_digit());
      end
    end
    if ($urandom_range(99) < 15) repeat ($urandom_range(1, 2)) t.push_back(pick_blank());
    if (t.size() > 0 && $urandom_range(99) < 12)
      t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255));
    if ($urandom_range(99) < 5) begin
      t.push_back(CH_NUL);
      repeat ($urandom_range(2)) t.push_back(8'($urandom_range(255)));
    end
    return t;
  endfunction

  task automatic run_random(int words);
    int target;
    target = words_sent + words;
    while (words_sent < target) send_text(make_text());
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Grammar corner cases at the reset settings: 64 bits, points allowed.
  task automatic test_parse_rules();
    text_t t;
    send_str("");
    send_str("  \t ");
    send_str("0");
    send_str("-0");
    send_str(" \t-42 \r");
    send_str("3.99");
    send_str("1.2 ");
    send_str("12e3");
    send_str("12E-1");
    send_str("e5");
    send_str(".");
    send_str("-");
    send_str("- ");
    send_str("1e");
    send_str("1e-");
    send_str("1e2.5");
    send_str("1e 7");
    send_str("7e99");
    send_str("-7e99");
    send_str("0e63");
    send_str("1 2");
    send_str("+1");
    // A zero byte ends the text early, whatever follows it.
    t = {CH_ZERO + 8'd1, CH_ZERO + 8'd2, CH_NUL, CH_LOW_E};
    send_text(t);
    t = {CH_NUL};
    send_text(t);
    t = {CH_ZERO + 8'd7, 8'hFF};
    send_text(t);
    // Empty words in the middle of a text change nothing.
    put_word(CH_ZERO + 8'd4, 1'b1, 1'b0);
    put_word(8'hA5, 1'b0, 1'b0);
    put_word(CH_ZERO + 8'd2, 1'b1, 1'b1);
  endtask

  // Range limits at every width, with and without strict mode.
  task automatic test_width_limits();
    for (int s = 1; s >= 0; s--) begin
      for (int w = 0; w < 4; w++) begin
        set_config(2'(w), 1'(s));
        send_text(boundary_text(1'b0, 1'b0));
        send_text(boundary_text(1'b1, 1'b0));
        send_text(boundary_text(1'b0, 1'b1));
        send_text(boundary_text(1'b1, 1'b1));
        send_str("1.5");
        send_str("2e1.0");
        send_str("-9e2");
      end
    end
  endtask

  // Random texts over a series of random register settings.
  task automatic test_random_mix();
    while (words_sent < ITEM_TARGET - 300) begin
      set_config(2'($urandom_range(3)), 1'($urandom_range(1)));
      run_random(150);
    end
  endtask

  // A stretch with both streams running flat out.
  task automatic test_no_idle();
    set_config(2'($urandom_range(3)), 1'b0);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_random(200);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // The receiver holds off while words keep coming, so the queue fills and
  // in_tready has to fall.
  task automatic test_back_pressure();
    set_config(2'd3, 1'b0);
    tx_gaps = 1'b0;
    hold_asks++;
    run_random(100);
    tx_gaps = 1'b1;
  endtask

  // ------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ------------------------------------------------------------------------

  // With idling on, out_tready is dropped at random about a third of the time,
  // and it is held low through a hold-off whenever one is asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= rx_gaps ? ($urandom_range(99) >= 32) : 1'b1;
    end
  end

  // Every word taken from the result stream is held against the oldest
  // expectation, one field at a time.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: value %0d ok %0b", $signed(out_tdata), out_tuser);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (out_tdata !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, $signed(out_tdata));
          errors++;
        end
        if (out_tuser !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_decimal_string_to_int_parser: errors");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_parse_rules();
    test_width_limits();
    test_random_mix();
    test_no_idle();
    test_back_pressure();
    settle();
    if (errors == 0) begin
      $display("tb_decimal_string_to_int_parser: clean");
    end else begin
      $display("tb_decimal_string_to_int_parser: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/dsip_pkg.sv
hdl/dsip_front.sv
hdl/dsip_queue.sv
hdl/dsip_back.sv
hdl/decimal_string_to_int_parser.sv
tb/tb_decimal_string_to_int_parser.sv
